// ===== hdl/gbfs_pkg.sv =====
// Package: shared constants and codes for the grid search block.
`timescale 1ns / 1ps
package gbfs_pkg;
   localparam int GRID_MAX_DEF = 64;
   localparam int DIST_W       = 12;
   localparam int SIZE_W       = 7;

   // Command codes
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   // Cell codes
   localparam logic [2:0] CODE_FREE   = 3'd0;
   localparam logic [2:0] CODE_WALL   = 3'd1;
   localparam logic [2:0] CODE_START  = 3'd2;
   localparam logic [2:0] CODE_TARGET = 3'd3;
   localparam logic [2:0] CODE_PATH   = 3'd4;

   // Neighbour directions in trace order
   localparam logic [1:0] DIR_LEFT  = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;
   localparam logic [1:0] DIR_UP    = 2'd3;
endpackage

// ===== hdl/gbfs_ram.sv =====
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module gbfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write, and register the old contents of the addressed entry
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule

// ===== hdl/grid_bfs_shortest_path.sv =====
// Top level: grid breadth-first search sequencer with cell, mark, distance and queue RAMs.
//
// Usage: one command beat enters on req_* when start is high and busy is low.
//   Load (req_operation 0) writes one cell and gives no result.
//   Search (1) floods from the start cell, traces the path back from the
//   target, and returns one result with rsp_found and rsp_distance.
//   Read (2) returns one result with rsp_cell_code (4 marks a path cell).
// Each result sits on rsp_* for exactly one cycle with rsp_valid high; the
// receiver cannot stall, so results are never held.
// Load writes in S_LOAD; read passes S_READ, S_READ_W and S_READ_OUT. Search
// first sweeps all GRID_MAX*GRID_MAX entries to clear marks and old path codes,
// then pops each queued cell and tests each in-grid neighbour (a neighbour off
// the grid is skipped at once), and finally traces the path back from the target.
// busy is high for the whole command, so commands run one at a time.
// csr_we writes grid_size (0 acts as 1, above GRID_MAX as GRID_MAX); the user
// must write it only while idle, as the block does not enforce this.
// Reset (synchronous, active high) clears control, start/target records and
// the result registers; the cell store keeps its contents, marks are cleared
// by the sweep of each search.
`timescale 1ns / 1ps
module grid_bfs_shortest_path
   import gbfs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_operation,
   input  logic [5:0]              req_row,
   input  logic [5:0]              req_col,
   input  logic [1:0]              req_cell_kind,
   output logic                    rsp_valid,
   output logic                    rsp_found,
   output logic [DIST_W-1:0]       rsp_distance,
   output logic [2:0]              rsp_cell_code,
   input  logic                    csr_we,
   input  logic [SIZE_W-1:0]       csr_wdata
);
   localparam int GRID_MAX = GRID_MAX_DEF;
   localparam int CW    = $clog2(GRID_MAX);
   localparam int AW    = 2 * CW;
   localparam int CELLS = GRID_MAX * GRID_MAX;
   localparam int QW    = AW + 1;

   typedef enum logic [4:0] {
      S_IDLE, S_LOAD, S_READ, S_READ_W, S_READ_OUT,
      S_CLR_RD, S_CLR_W, S_CLR_WR, S_CHECK,
      S_DEQ_RD, S_DEQ_W, S_DEQ_GOT, S_NB_RD, S_NB_W, S_NB_CHK,
      S_TR_START, S_TR_W, S_TR_GOT, S_TR_NB, S_TR_NBW, S_TR_NBCHK,
      S_DONE
   } state_type;

   state_type          state_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [AW-1:0]      start_pos_ff, target_pos_ff;
   logic [1:0]         have_ff;
   logic               found_ff;
   logic [DIST_W-1:0]  pdist_ff;
   logic [AW-1:0]      cur_ff, nb_ff;
   logic [QW-1:0]      head_ff, tail_ff, sweep_ff;
   logic [1:0]         dir_ff;
   logic [DIST_W:0]    cd_ff;
   logic [DIST_W:0]    pd_ff;
   logic               rsp_valid_ff;
   logic [2:0]         rsp_code_ff;
   logic [CW-1:0]      row_ff, col_ff;
   logic [1:0]         kind_ff;
   logic               addr_ok_ff;

   // RAM ports
   logic               c_we, v_we, d_we, q_we;
   logic [AW-1:0]      c_addr, v_addr, d_addr, q_addr;
   logic [2:0]         c_wd, c_rd;
   logic [0:0]         v_wd, v_rd;
   logic [DIST_W:0]    d_wd, d_rd;
   logic [AW-1:0]      q_wd, q_rd;

   gbfs_ram #(.WIDTH(3), .DEPTH(CELLS)) u_cell (
      .clock(clock), .we(c_we), .addr(c_addr), .wdata(c_wd), .rdata(c_rd));
   gbfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_mark (
      .clock(clock), .we(v_we), .addr(v_addr), .wdata(v_wd), .rdata(v_rd));
   gbfs_ram #(.WIDTH(DIST_W + 1), .DEPTH(CELLS)) u_dist (
      .clock(clock), .we(d_we), .addr(d_addr), .wdata(d_wd), .rdata(d_rd));
   gbfs_ram #(.WIDTH(AW), .DEPTH(CELLS)) u_queue (
      .clock(clock), .we(q_we), .addr(q_addr), .wdata(q_wd), .rdata(q_rd));

   // Clamp grid side
   logic [SIZE_W-1:0] side;
   always_comb begin
      if (size_ff == '0) side = SIZE_W'(1);
      else if (32'(size_ff) > GRID_MAX) side = SIZE_W'(GRID_MAX);
      else side = size_ff;
   end

   function automatic logic in_grid(input logic [AW-1:0] p, input logic [SIZE_W-1:0] n);
      in_grid = (SIZE_W'(p[AW-1:CW]) < n) && (SIZE_W'(p[CW-1:0]) < n);
   endfunction

   // Neighbour address and bound check for the current direction
   logic [CW-1:0] cr, cc;
   logic [AW-1:0] nb_addr;
   logic          nb_ok;
   always_comb begin
      cr = cur_ff[AW-1:CW];
      cc = cur_ff[CW-1:0];
      nb_ok = 1'b0;
      nb_addr = cur_ff;
      case (dir_ff)
         DIR_LEFT: begin
            nb_ok = (cc != '0);
            nb_addr = {cr, cc - CW'(1)};
         end
         DIR_RIGHT: begin
            nb_ok = (SIZE_W'(cc) + SIZE_W'(1) < side);
            nb_addr = {cr, cc + CW'(1)};
         end
         DIR_DOWN: begin
            nb_ok = (SIZE_W'(cr) + SIZE_W'(1) < side);
            nb_addr = {cr + CW'(1), cc};
         end
         DIR_UP: begin
            nb_ok = (cr != '0);
            nb_addr = {cr - CW'(1), cc};
         end
         default: begin
            nb_ok = 1'b0;
         end
      endcase
   end

   logic req_ok;
   assign req_ok = (32'(req_row) < GRID_MAX) && (32'(req_col) < GRID_MAX);
   logic [AW-1:0] cmd_idx;
   assign cmd_idx = {row_ff, col_ff};

   // RAM drive
   always_comb begin
      c_we = 1'b0; v_we = 1'b0; d_we = 1'b0; q_we = 1'b0;
      c_addr = cmd_idx; v_addr = cmd_idx; d_addr = cmd_idx; q_addr = head_ff[AW-1:0];
      c_wd = CODE_FREE; v_wd = 1'b0; d_wd = '0; q_wd = nb_ff;
      case (state_ff)
         S_LOAD: begin
            c_addr = cmd_idx;
            c_we = addr_ok_ff;
            c_wd = {1'b0, kind_ff};
         end
         S_READ: begin
            c_addr = cmd_idx;
         end
         S_CLR_RD: begin
            c_addr = sweep_ff[AW-1:0];
            v_addr = sweep_ff[AW-1:0];
            v_we = 1'b1;
         end
         S_CLR_W: begin
            c_addr = sweep_ff[AW-1:0];
         end
         S_CLR_WR: begin
            c_addr = sweep_ff[AW-1:0];
            c_we = (c_rd == CODE_PATH) ||
                   (have_ff[1] && sweep_ff[AW-1:0] == target_pos_ff);
            c_wd = (have_ff[1] && sweep_ff[AW-1:0] == target_pos_ff) ? CODE_TARGET : CODE_FREE;
         end
         S_CHECK: begin
            v_addr = start_pos_ff; v_wd = 1'b1;
            d_addr = start_pos_ff; d_wd = '0;
            q_addr = '0; q_wd = start_pos_ff;
            if (have_ff == 2'b11 && in_grid(start_pos_ff, side) &&
                in_grid(target_pos_ff, side)) begin
               v_we = 1'b1; d_we = 1'b1; q_we = 1'b1;
            end
         end
         S_DEQ_RD: begin
            q_addr = head_ff[AW-1:0];
         end
         S_DEQ_GOT: begin
            d_addr = q_rd;
         end
         S_NB_RD, S_NB_W: begin
            c_addr = nb_addr; v_addr = nb_addr;
         end
         S_NB_CHK: begin
            v_addr = nb_ff; d_addr = nb_ff; q_addr = tail_ff[AW-1:0];
            v_wd = 1'b1; d_wd = pd_ff + 1'b1; q_wd = nb_ff;
            if (c_rd != CODE_WALL && !v_rd[0] && 32'(tail_ff) < CELLS) begin
               v_we = 1'b1; d_we = 1'b1; q_we = 1'b1;
            end
         end
         S_TR_START: begin
            v_addr = target_pos_ff; d_addr = target_pos_ff;
         end
         S_TR_GOT: begin
            c_addr = cur_ff; c_we = 1'b1; c_wd = CODE_PATH;
         end
         S_TR_NB, S_TR_NBW: begin
            c_addr = nb_addr; v_addr = nb_addr; d_addr = nb_addr;
         end
         default: begin
         end
      endcase
   end

   // Sequencer: control state and registered outputs
   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
         size_ff <= SIZE_W'(GRID_MAX_DEF);
         start_pos_ff <= '0; target_pos_ff <= '0; have_ff <= '0;
         found_ff <= 1'b0; pdist_ff <= '0; rsp_code_ff <= CODE_FREE;
         head_ff <= '0; tail_ff <= '0; sweep_ff <= '0;
      end else begin
         if (csr_we) size_ff <= csr_wdata;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  row_ff <= CW'(req_row); col_ff <= CW'(req_col);
                  kind_ff <= req_cell_kind;
                  addr_ok_ff <= req_ok;
                  case (req_operation)
                     OP_LOAD: state_ff <= S_LOAD;
                     OP_READ: state_ff <= S_READ;
                     OP_SEARCH: begin
                        sweep_ff <= '0;
                        found_ff <= 1'b0; pdist_ff <= '0;
                        state_ff <= S_CLR_RD;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_LOAD: begin
               if (addr_ok_ff) begin
                  if ({1'b0, kind_ff} == CODE_START) begin
                     start_pos_ff <= cmd_idx; have_ff[0] <= 1'b1;
                  end else if (start_pos_ff == cmd_idx) have_ff[0] <= 1'b0;
                  if ({1'b0, kind_ff} == CODE_TARGET) begin
                     target_pos_ff <= cmd_idx; have_ff[1] <= 1'b1;
                  end else if (target_pos_ff == cmd_idx) have_ff[1] <= 1'b0;
               end
               state_ff <= S_IDLE;
            end
            S_READ: state_ff <= S_READ_W;
            S_READ_W: state_ff <= S_READ_OUT;
            S_READ_OUT: begin
               rsp_code_ff <= addr_ok_ff ? c_rd : CODE_FREE;
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            // Sweep: clear mark, read code; then fix path/target codes
            S_CLR_RD: state_ff <= S_CLR_W;
            S_CLR_W: state_ff <= S_CLR_WR;
            S_CLR_WR: begin
               if (32'(sweep_ff) == CELLS - 1) state_ff <= S_CHECK;
               else state_ff <= S_CLR_RD;
               sweep_ff <= sweep_ff + 1'b1;
            end
            S_CHECK: begin
               rsp_code_ff <= CODE_FREE;
               if (have_ff == 2'b11 && in_grid(start_pos_ff, side) &&
                   in_grid(target_pos_ff, side)) begin
                  head_ff <= '0; tail_ff <= QW'(1);
                  state_ff <= S_DEQ_RD;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            // Flood: pop a cell, fetch its distance, test each neighbour
            S_DEQ_RD: begin
               if (head_ff == tail_ff) state_ff <= S_TR_START;
               else state_ff <= S_DEQ_W;
            end
            S_DEQ_W: state_ff <= S_DEQ_GOT;
            S_DEQ_GOT: begin
               cur_ff <= q_rd; head_ff <= head_ff + 1'b1;
               dir_ff <= DIR_LEFT;
               state_ff <= S_NB_RD;
            end
            S_NB_RD: begin
               // distance of the popped cell arrives on the first direction only
               if (dir_ff == DIR_LEFT) pd_ff <= d_rd;
               nb_ff <= nb_addr;
               state_ff <= nb_ok ? S_NB_W : S_NB_CHK;
               if (!nb_ok) begin
                  if (dir_ff == DIR_UP) state_ff <= S_DEQ_RD;
                  else begin
                     dir_ff <= dir_ff + 1'b1;
                     state_ff <= S_NB_RD;
                  end
               end
            end
            S_NB_W: state_ff <= S_NB_CHK;
            S_NB_CHK: begin
               if (c_rd != CODE_WALL && !v_rd[0] && 32'(tail_ff) < CELLS)
                  tail_ff <= tail_ff + 1'b1;
               if (dir_ff == DIR_UP) state_ff <= S_DEQ_RD;
               else begin
                  dir_ff <= dir_ff + 1'b1;
                  state_ff <= S_NB_RD;
               end
            end
            // Trace back from target
            S_TR_START: state_ff <= S_TR_W;
            S_TR_W: begin
               if (v_rd[0]) begin
                  found_ff <= 1'b1;
                  pdist_ff <= (d_rd > (DIST_W + 1)'(4095)) ? DIST_W'(4095) : d_rd[DIST_W-1:0];
                  cd_ff <= d_rd;
                  cur_ff <= target_pos_ff;
                  state_ff <= (d_rd == '0) ? S_DONE : S_TR_GOT;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_TR_GOT: begin
               dir_ff <= DIR_LEFT;
               state_ff <= S_TR_NB;
            end
            S_TR_NB: begin
               if (nb_ok) state_ff <= S_TR_NBW;
               else if (dir_ff == DIR_UP) state_ff <= S_DONE;
               else dir_ff <= dir_ff + 1'b1;
            end
            S_TR_NBW: state_ff <= S_TR_NBCHK;
            S_TR_NBCHK: begin
               if (c_rd != CODE_WALL && v_rd[0] && d_rd == cd_ff - 1'b1) begin
                  cur_ff <= nb_addr;
                  cd_ff <= cd_ff - 1'b1;
                  state_ff <= (cd_ff == (DIST_W + 1)'(1)) ? S_DONE : S_TR_GOT;
               end else if (dir_ff == DIR_UP) state_ff <= S_DONE;
               else begin
                  dir_ff <= dir_ff + 1'b1;
                  state_ff <= S_TR_NB;
               end
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = found_ff;
   assign rsp_distance  = pdist_ff;
   assign rsp_cell_code = rsp_code_ff;

   // Queue never passes its tail
   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      (head_ff <= tail_ff)) else $error("queue head passed tail");
   // A result never appears while a command is still in flight
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   // A result without found reports a zero distance
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_distance == '0)) else $error("distance without found");
   // Accepted command other than a no-op makes the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation != OP_NOP) |=> busy) else $error("accept not registered");
endmodule
